// ----- hdl/file_delivery_pdu_header_parser_top_macros.svh -----
// ----------------------------------------------------------------------------
// file_delivery_pdu_header_parser_top_macros.svh
// assertion helpers used by the header parser queue
// ----------------------------------------------------------------------------
`ifndef FILE_DELIVERY_PDU_HEADER_PARSER_TOP_MACROS_SVH
`define FILE_DELIVERY_PDU_HEADER_PARSER_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define FDPHP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// next-cycle implication, checked out of reset
`define FDPHP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// ----- hdl/fdphp_pkg.sv -----
// ----------------------------------------------------------------------------
// fdphp_pkg
// types shared by the pdu header parser front end, queue and back end
// ----------------------------------------------------------------------------
package fdphp_pkg;

    // width of the entity id / sequence number accumulators (max 4 bytes)
    localparam int unsigned ACC_W = 32;
    localparam int unsigned OUT_W = 64;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_BAD_ID  = 2'd1,
        STATUS_BAD_SEQ = 2'd2
    } status_t;

    // one parsed header as it travels from front end to back end
    typedef struct packed {
        logic [7:1]       flags;
        logic [15:0]      length;
        logic [2:0]       id_code;
        logic [2:0]       seq_code;
        logic [ACC_W-1:0] src;
        logic [ACC_W-1:0] seq;
        logic [ACC_W-1:0] dst;
        status_t          status;
    } result_t;

endpackage

// ----- hdl/fdphp_front.sv -----
// ----------------------------------------------------------------------------
// fdphp_front
// byte-serial header parser: tracks byte position and builds result records
// ----------------------------------------------------------------------------
module fdphp_front
    import fdphp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,
    input  logic [7:0] data_byte,
    input  logic       first_byte,
    output logic       res_valid,
    output result_t    res
);

    localparam logic [3:0] POS_LEN_HI  = 4'd1;
    localparam logic [3:0] POS_LEN_LO  = 4'd2;
    localparam logic [3:0] POS_LENGTHS = 4'd3;
    localparam logic [3:0] POS_BODY    = 4'd4;

    // supported length codes: 1, 2 or 4 bytes
    function automatic logic len_ok(input logic [2:0] code);
        len_ok = (code inside {3'd1, 3'd2, 3'd4});
    endfunction

    logic [3:0]       pos_reg, pos_next;
    logic             done_reg, done_next;
    logic [7:1]       flags_reg, flags_next;
    logic [15:0]      len_reg, len_next;
    logic [2:0]       idc_reg, idc_next;
    logic [2:0]       sqc_reg, sqc_next;
    logic [ACC_W-1:0] src_reg, src_next;
    logic [ACC_W-1:0] seq_reg, seq_next;
    logic [ACC_W-1:0] dst_reg, dst_next;

    logic [3:0] rel;
    logic [3:0] id_plus_seq;
    logic [4:0] hdr_len;
    logic [4:0] pos_inc;
    logic       emit;
    status_t    st;

    // body byte bookkeeping
    assign rel         = pos_reg - POS_BODY;
    assign id_plus_seq = {1'b0, idc_reg} + {1'b0, sqc_reg};
    assign hdr_len     = 5'd4 + {1'b0, idc_reg, 1'b0} + {2'b0, sqc_reg};
    assign pos_inc     = {1'b0, pos_reg} + 5'd1;

    // parse step
    always_comb
    begin
        pos_next   = pos_reg;
        done_next  = done_reg;
        flags_next = flags_reg;
        len_next   = len_reg;
        idc_next   = idc_reg;
        sqc_next   = sqc_reg;
        src_next   = src_reg;
        seq_next   = seq_reg;
        dst_next   = dst_reg;
        emit       = 1'b0;
        st         = STATUS_OK;
        if (first_byte)
        begin
            flags_next = data_byte[7:1];
            len_next   = '0;
            idc_next   = '0;
            sqc_next   = '0;
            src_next   = '0;
            seq_next   = '0;
            dst_next   = '0;
            pos_next   = POS_LEN_HI;
            done_next  = 1'b0;
        end
        else if (!done_reg)
        begin
            case (pos_reg)
                POS_LEN_HI, POS_LEN_LO:
                begin
                    len_next = {len_reg[7:0], data_byte};
                    pos_next = pos_inc[3:0];
                end
                POS_LENGTHS:
                begin
                    idc_next = data_byte[6:4];
                    sqc_next = data_byte[2:0];
                    if (!len_ok(data_byte[6:4]))
                    begin
                        done_next = 1'b1;
                        emit      = 1'b1;
                        st        = STATUS_BAD_ID;
                    end
                    else if (!len_ok(data_byte[2:0]))
                    begin
                        done_next = 1'b1;
                        emit      = 1'b1;
                        st        = STATUS_BAD_SEQ;
                    end
                    else
                    begin
                        pos_next = POS_BODY;
                    end
                end
                default:
                begin
                    // ids and sequence number, big-endian
                    if (rel < {1'b0, idc_reg})
                        src_next = {src_reg[ACC_W-9:0], data_byte};
                    else if (rel < id_plus_seq)
                        seq_next = {seq_reg[ACC_W-9:0], data_byte};
                    else
                        dst_next = {dst_reg[ACC_W-9:0], data_byte};
                    if (pos_inc >= hdr_len)
                    begin
                        done_next = 1'b1;
                        pos_next  = '0;
                        emit      = 1'b1;
                    end
                    else
                    begin
                        pos_next = pos_inc[3:0];
                    end
                end
            endcase
        end
    end

    assign res_valid    = take && emit;
    assign res.flags    = flags_next;
    assign res.length   = len_next;
    assign res.id_code  = idc_next;
    assign res.seq_code = sqc_next;
    assign res.src      = src_next;
    assign res.seq      = seq_next;
    assign res.dst      = dst_next;
    assign res.status   = st;

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            done_reg  <= 1'b1;
            flags_reg <= '0;
            len_reg   <= '0;
            idc_reg   <= '0;
            sqc_reg   <= '0;
            src_reg   <= '0;
            seq_reg   <= '0;
            dst_reg   <= '0;
        end
        else if (take)
        begin
            pos_reg   <= pos_next;
            done_reg  <= done_next;
            flags_reg <= flags_next;
            len_reg   <= len_next;
            idc_reg   <= idc_next;
            sqc_reg   <= sqc_next;
            src_reg   <= src_next;
            seq_reg   <= seq_next;
            dst_reg   <= dst_next;
        end
    end

endmodule

// ----- hdl/fdphp_queue.sv -----
// ----------------------------------------------------------------------------
// fdphp_queue
// small first-in first-out buffer of parsed header records
// ----------------------------------------------------------------------------
`include "file_delivery_pdu_header_parser_top_macros.svh"

module fdphp_queue
    import fdphp_pkg::*;
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    wr_en,
    input  result_t wr_data,
    input  logic    rd_en,
    output result_t rd_data,
    output logic    q_full,
    output logic    q_empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    result_t          mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign q_full  = (cnt_reg == CNT_FULL);
    assign q_empty = (cnt_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (rd_en)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (wr_en && !rd_en)
            cnt_next = cnt_reg + 1'b1;
        else if (rd_en && !wr_en)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // record storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    `FDPHP_ASSERT_IMP(a_no_write_when_full, clk, rst_n, wr_en, !q_full)
    `FDPHP_ASSERT_IMP(a_no_read_when_empty, clk, rst_n, rd_en, !q_empty)
    `FDPHP_ASSERT_NXT(a_count_tracks_ptrs, clk, rst_n, wr_en && !rd_en, cnt_reg == $past(cnt_reg) + 1'b1)

endmodule

// ----- hdl/fdphp_back.sv -----
// ----------------------------------------------------------------------------
// fdphp_back
// result output stage: holds the oldest record and widens it to the ports
// ----------------------------------------------------------------------------
module fdphp_back
    import fdphp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_empty,
    input  result_t      q_data,
    output logic         q_rd,
    input  logic         pop,
    output logic         empty,
    output logic [2:0]   version,
    output logic         pdu_kind,
    output logic         direction,
    output logic         tx_mode,
    output logic         crc_present,
    output logic [15:0]  data_field_length,
    output logic [2:0]   id_length,
    output logic [2:0]   seq_length,
    output logic [OUT_W-1:0] src_entity_id,
    output logic [OUT_W-1:0] sequence_number,
    output logic [OUT_W-1:0] dst_entity_id,
    output logic [1:0]   status
);

    logic    valid_reg, valid_next;
    result_t out_reg;
    logic    ok;

    // refill the output register when it is free or being taken
    assign q_rd       = !q_empty && (!valid_reg || pop);
    assign valid_next = q_rd || (valid_reg && !pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (q_rd)
            out_reg <= q_data;
    end

    // field unpacking; ids read as zero on an error item
    assign ok                = (out_reg.status == STATUS_OK);
    assign empty             = !valid_reg;
    assign version           = out_reg.flags[7:5];
    assign pdu_kind          = out_reg.flags[4];
    assign direction         = out_reg.flags[3];
    assign tx_mode           = out_reg.flags[2];
    assign crc_present       = out_reg.flags[1];
    assign data_field_length = out_reg.length;
    assign id_length         = out_reg.id_code;
    assign seq_length        = out_reg.seq_code;
    assign src_entity_id     = ok ? {{(OUT_W-ACC_W){1'b0}}, out_reg.src} : '0;
    assign sequence_number   = ok ? {{(OUT_W-ACC_W){1'b0}}, out_reg.seq} : '0;
    assign dst_entity_id     = ok ? {{(OUT_W-ACC_W){1'b0}}, out_reg.dst} : '0;
    assign status            = out_reg.status;

endmodule

// ----- hdl/file_delivery_pdu_header_parser_top.sv -----
// ----------------------------------------------------------------------------
// file_delivery_pdu_header_parser_top
// byte-serial file delivery pdu fixed-header parser
// ----------------------------------------------------------------------------
// Takes one pdu byte per cycle, every cycle, while full is low; each byte
// needs only a shift and a compare, so nothing else limits the rate.
// first_byte restarts parsing. One item comes out per header (or one error
// item at the length byte); with no older item waiting it passes through
// the queue storage and then the output register to the result ports.
// Results sit in a QUEUE_DEPTH-entry queue behind a registered output
// stage, so full only rises once the queue and the output register are
// all occupied by results not yet popped.
module file_delivery_pdu_header_parser_top
    import fdphp_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [7:0]       data_byte,
    input  logic             first_byte,
    input  logic             pop,
    output logic             empty,
    output logic [2:0]       version,
    output logic             pdu_kind,
    output logic             direction,
    output logic             tx_mode,
    output logic             crc_present,
    output logic [15:0]      data_field_length,
    output logic [2:0]       id_length,
    output logic [2:0]       seq_length,
    output logic [OUT_W-1:0] src_entity_id,
    output logic [OUT_W-1:0] sequence_number,
    output logic [OUT_W-1:0] dst_entity_id,
    output logic [1:0]       status
);

    logic    take;
    logic    res_valid;
    result_t res;
    logic    q_full;
    logic    q_empty;
    logic    q_rd;
    result_t q_data;

    // a byte is taken whenever the queue has room for a possible result
    assign full = q_full;
    assign take = push && !q_full;

    // front end: parsing
    fdphp_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .data_byte  (data_byte),
        .first_byte (first_byte),
        .res_valid  (res_valid),
        .res        (res)
    );

    // decoupling queue
    fdphp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_valid),
        .wr_data (res),
        .rd_en   (q_rd),
        .rd_data (q_data),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    // back end: output register
    fdphp_back u_back
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .q_empty           (q_empty),
        .q_data            (q_data),
        .q_rd              (q_rd),
        .pop               (pop),
        .empty             (empty),
        .version           (version),
        .pdu_kind          (pdu_kind),
        .direction         (direction),
        .tx_mode           (tx_mode),
        .crc_present       (crc_present),
        .data_field_length (data_field_length),
        .id_length         (id_length),
        .seq_length        (seq_length),
        .src_entity_id     (src_entity_id),
        .sequence_number   (sequence_number),
        .dst_entity_id     (dst_entity_id),
        .status            (status)
    );

endmodule

// ----- verif/file_delivery_pdu_header_parser_top_tb.sv -----
// ----------------------------------------------------------------------------
// file_delivery_pdu_header_parser_top_tb
// pdu header parser checked byte by byte against a local parser model
// ----------------------------------------------------------------------------
// A queue of pdu bytes is built up front: a directed part covering field
// extremes, every length code, the error paths and restarts, then random
// headers with trailing data, broken headers and noise. A clocked sender
// offers the bytes with random gaps. Every byte taken is run through a
// local header parser, which stores the header items that should come out.
// A clocked receiver pops with random stalls and compares each item field
// by field. Twice the receiver holds off for a long stretch so that the
// result queue fills and the input stalls.
module file_delivery_pdu_header_parser_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import fdphp_pkg::*;

    localparam int unsigned ITEM_TARGET = 1650;
    localparam int unsigned LONG_HOLD   = 400;
    localparam int unsigned WHOLE       = 64;

    typedef enum int unsigned {
        FILL_ZERO,
        FILL_ONES,
        FILL_RANDOM
    } fill_t;

    typedef struct {
        logic [7:0] value;
        logic       marker;
    } pdu_byte_t;

    typedef struct {
        logic [2:0]  version;
        logic        pdu_kind;
        logic        direction;
        logic        mode;
        logic        crc;
        logic [15:0] dlen;
        logic [2:0]  idc;
        logic [2:0]  seqc;
        logic [63:0] src;
        logic [63:0] seqn;
        logic [63:0] dst;
        status_t     result_status;
    } header_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              push = 1'b0;
    logic              full;
    logic [7:0]        data_byte = 8'd0;
    logic              first_byte = 1'b0;
    logic              pop = 1'b0;
    logic              empty;
    logic [2:0]        version;
    logic              pdu_kind;
    logic              direction;
    logic              tx_mode;
    logic              crc_present;
    logic [15:0]       data_field_length;
    logic [2:0]        id_length;
    logic [2:0]        seq_length;
    logic [OUT_W-1:0]  src_entity_id;
    logic [OUT_W-1:0]  sequence_number;
    logic [OUT_W-1:0]  dst_entity_id;
    logic [1:0]        status;

    pdu_byte_t   pending_bytes[$];
    header_t     expected_headers[$];
    int unsigned bytes_taken = 0;
    int unsigned mismatches = 0;
    logic        receiver_held = 1'b0;

    // parser model state
    logic [4:0]  pos_q = 5'd0;
    logic [7:0]  flags_q = 8'd0;
    logic [15:0] len_q = 16'd0;
    logic [2:0]  idc_q = 3'd0;
    logic [2:0]  seqc_q = 3'd0;
    logic [63:0] src_q = 64'd0;
    logic [63:0] seqn_q = 64'd0;
    logic [63:0] dst_q = 64'd0;
    logic        idle_q = 1'b1;

    file_delivery_pdu_header_parser_top u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .push              (push),
        .full              (full),
        .data_byte         (data_byte),
        .first_byte        (first_byte),
        .pop               (pop),
        .empty             (empty),
        .version           (version),
        .pdu_kind          (pdu_kind),
        .direction         (direction),
        .tx_mode           (tx_mode),
        .crc_present       (crc_present),
        .data_field_length (data_field_length),
        .id_length         (id_length),
        .seq_length        (seq_length),
        .src_entity_id     (src_entity_id),
        .sequence_number   (sequence_number),
        .dst_entity_id     (dst_entity_id),
        .status            (status)
    );

    always #1 clk = ~clk;

    // lengths of 1, 2 or 4 bytes are supported
    function automatic logic code_ok(logic [2:0] code);
        return code == 3'd1 || code == 3'd2 || code == 3'd4;
    endfunction

    function automatic logic [2:0] valid_code();
        case ($urandom_range(0, 2))
            0: return 3'd1;
            1: return 3'd2;
            default: return 3'd4;
        endcase
    endfunction

    function automatic logic [2:0] bad_code();
        logic [2:0] code;
        code = 3'($urandom);
        while (code_ok(code))
            code = 3'($urandom);
        return code;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    function automatic void store_header(status_t st);
        header_t h;
        h.version       = flags_q[7:5];
        h.pdu_kind      = flags_q[4];
        h.direction     = flags_q[3];
        h.mode          = flags_q[2];
        h.crc           = flags_q[1];
        h.dlen          = len_q;
        h.idc           = idc_q;
        h.seqc          = seqc_q;
        h.src           = (st == STATUS_OK) ? src_q : 64'd0;
        h.seqn          = (st == STATUS_OK) ? seqn_q : 64'd0;
        h.dst           = (st == STATUS_OK) ? dst_q : 64'd0;
        h.result_status = st;
        expected_headers.push_back(h);
    endfunction

    // one byte through the header parser model
    function automatic void parse_byte(logic [7:0] b, logic marker);
        int unsigned rel;
        int unsigned hdr_len;
        if (marker)
        begin
            flags_q = b;
            len_q   = 16'd0;
            idc_q   = 3'd0;
            seqc_q  = 3'd0;
            src_q   = 64'd0;
            seqn_q  = 64'd0;
            dst_q   = 64'd0;
            pos_q   = 5'd1;
            idle_q  = 1'b0;
            return;
        end
        if (idle_q)
            return;
        case (pos_q)
            5'd1, 5'd2:
            begin
                len_q = {len_q[7:0], b};
                pos_q = pos_q + 5'd1;
            end
            5'd3:
            begin
                idc_q  = b[6:4];
                seqc_q = b[2:0];
                if (!code_ok(idc_q))
                begin
                    idle_q = 1'b1;
                    store_header(STATUS_BAD_ID);
                end
                else if (!code_ok(seqc_q))
                begin
                    idle_q = 1'b1;
                    store_header(STATUS_BAD_SEQ);
                end
                else
                    pos_q = 5'd4;
            end
            default:
            begin
                rel = pos_q - 4;
                if (rel < idc_q)
                    src_q = {src_q[55:0], b};
                else if (rel < idc_q + seqc_q)
                    seqn_q = {seqn_q[55:0], b};
                else
                    dst_q = {dst_q[55:0], b};
                hdr_len = 4 + 2 * idc_q + seqc_q;
                if (pos_q + 1 >= hdr_len)
                begin
                    idle_q = 1'b1;
                    pos_q  = 5'd0;
                    store_header(STATUS_OK);
                end
                else
                    pos_q = pos_q + 5'd1;
            end
        endcase
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    // queue a header, cut short after keep bytes
    task automatic add_header(input logic [7:0] flags, input logic [15:0] dlen,
                              input logic [7:0] codes, input fill_t fill,
                              input int unsigned keep);
        int unsigned total;
        pdu_byte_t   pb;
        total = 4;
        if (code_ok(codes[6:4]) && code_ok(codes[2:0]))
            total = 4 + 2 * codes[6:4] + codes[2:0];
        for (int unsigned i = 0; i < total && i < keep; i++)
        begin
            case (i)
                0: pb.value = flags;
                1: pb.value = dlen[15:8];
                2: pb.value = dlen[7:0];
                3: pb.value = codes;
                default:
                    case (fill)
                        FILL_ZERO: pb.value = 8'h00;
                        FILL_ONES: pb.value = 8'hFF;
                        default:   pb.value = 8'($urandom);
                    endcase
            endcase
            pb.marker = (i == 0);
            pending_bytes.push_back(pb);
        end
    endtask

    task automatic add_noise(input int unsigned n, input int unsigned marker_pct);
        pdu_byte_t pb;
        repeat (n)
        begin
            pb.value  = 8'($urandom);
            pb.marker = ($urandom_range(0, 99) < marker_pct);
            pending_bytes.push_back(pb);
        end
    endtask

    // sender: offers queued bytes, models every byte taken
    always @(posedge clk)
    begin : sender
        logic        take;
        pdu_byte_t   nxt;
        int unsigned gap;
        int unsigned burst;
        take = push && !full;
        if (rst_n)
        begin
            if (take)
            begin
                parse_byte(data_byte, first_byte);
                bytes_taken++;
            end
            if (take || !push)
            begin
                if (gap > 0)
                begin
                    gap--;
                    push <= 1'b0;
                end
                else if (pending_bytes.size() != 0)
                begin
                    nxt = pending_bytes.pop_front();
                    push       <= 1'b1;
                    data_byte  <= nxt.value;
                    first_byte <= nxt.marker;
                    if (burst > 0)
                    begin
                        burst--;
                        gap = 0;
                    end
                    else
                    begin
                        gap = idle_len();
                        if ($urandom_range(0, 49) == 0)
                            burst = $urandom_range(50, 200);
                    end
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // receiver: pops with random stalls and checks each item
    always @(posedge clk)
    begin : receiver
        header_t     want;
        int unsigned stall;
        int unsigned burst;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (expected_headers.size() == 0)
                begin
                    $error("result item with none expected, status %0d", status);
                    mismatches++;
                end
                else
                begin
                    want = expected_headers.pop_front();
                    check_field("version", want.version, version);
                    check_field("pdu_kind", want.pdu_kind, pdu_kind);
                    check_field("direction", want.direction, direction);
                    check_field("tx_mode", want.mode, tx_mode);
                    check_field("crc_present", want.crc, crc_present);
                    check_field("data_field_length", want.dlen, data_field_length);
                    check_field("id_length", want.idc, id_length);
                    check_field("seq_length", want.seqc, seq_length);
                    check_field("src_entity_id", want.src, src_entity_id);
                    check_field("sequence_number", want.seqn, sequence_number);
                    check_field("dst_entity_id", want.dst, dst_entity_id);
                    check_field("status", want.result_status, status);
                end
            end
            if (receiver_held)
                pop <= 1'b0;
            else if (stall > 0)
            begin
                stall--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
                if (burst > 0)
                begin
                    burst--;
                    stall = 0;
                end
                else
                begin
                    stall = idle_len();
                    if ($urandom_range(0, 49) == 0)
                        burst = $urandom_range(50, 200);
                end
            end
        end
    end

    // long receiver hold-offs so the result queue fills and full rises
    initial
    begin : long_hold
        for (int unsigned k = 0; k < 2; k++)
        begin
            wait (bytes_taken >= 250 + 750 * k);
            @(posedge clk);
            receiver_held <= 1'b1;
            repeat (LONG_HOLD) @(posedge clk);
            receiver_held <= 1'b0;
        end
    end

    // stimulus, reset and end of run
    initial
    begin : stimulus
        logic [7:0]  codes;
        int unsigned r;
        fill_t       fill;

        // idle after reset: unmarked bytes are ignored
        add_noise(3, 0);
        // field extremes and every supported length
        add_header(8'h00, 16'h0000, 8'h11, FILL_ZERO, WHOLE);
        add_header(8'hFF, 16'hFFFF, 8'hCC, FILL_ONES, WHOLE);
        add_header(8'hA5, 16'h1234, 8'h22, FILL_RANDOM, WHOLE);
        add_header(8'h5A, 16'h8001, 8'h14, FILL_RANDOM, WHOLE);
        add_header(8'h3C, 16'h00FF, 8'hC1, FILL_ONES, WHOLE);
        add_header(8'hC3, 16'hFF00, 8'h21, FILL_RANDOM, WHOLE);
        // trailing data bytes after a header are ignored
        add_noise(3, 0);
        // bad id length, bad sequence length too: id is reported
        add_header(8'h81, 16'h0102, 8'h00, FILL_RANDOM, WHOLE);
        add_header(8'h42, 16'h0304, 8'hF7, FILL_RANDOM, WHOLE);
        add_header(8'h24, 16'h0506, 8'h30, FILL_RANDOM, WHOLE);
        // good id length, bad sequence length
        add_header(8'h18, 16'h0708, 8'h13, FILL_RANDOM, WHOLE);
        add_header(8'hE7, 16'h090A, 8'hC5, FILL_RANDOM, WHOLE);
        add_header(8'h7E, 16'h0B0C, 8'h26, FILL_RANDOM, WHOLE);
        add_header(8'h99, 16'h0D0E, 8'h9F, FILL_RANDOM, WHOLE);
        add_header(8'h66, 16'h0F10, 8'h18, FILL_RANDOM, WHOLE);
        // bytes after an error result are ignored
        add_noise(4, 0);
        // marker mid-header drops the header in progress
        add_header(8'h11, 16'h2222, 8'h44, FILL_RANDOM, 2);
        add_header(8'h33, 16'h4444, 8'h44, FILL_RANDOM, 9);
        add_header(8'h55, 16'h6666, 8'h42, FILL_RANDOM, WHOLE);

        // random part: mostly well-formed headers with random content
        while (pending_bytes.size() < ITEM_TARGET)
        begin
            r = $urandom_range(0, 99);
            codes = 8'($urandom);
            codes[6:4] = valid_code();
            codes[2:0] = valid_code();
            fill = ($urandom_range(0, 9) == 0) ? FILL_ONES : FILL_RANDOM;
            if (r < 70)
            begin
                add_header(8'($urandom), 16'($urandom), codes, fill, WHOLE);
                add_noise($urandom_range(0, 4), 0);
            end
            else if (r < 80)
            begin
                if ($urandom_range(0, 1) != 0)
                    codes[6:4] = bad_code();
                else
                    codes[2:0] = bad_code();
                add_header(8'($urandom), 16'($urandom), codes, fill, WHOLE);
                add_noise($urandom_range(0, 3), 0);
            end
            else if (r < 88)
                add_header(8'($urandom), 16'($urandom), codes, fill,
                           $urandom_range(1, 15));
            else
                add_noise($urandom_range(1, 6), 15);
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // drain: everything sent, every expected item received
        while (pending_bytes.size() != 0 || push)
            @(posedge clk);
        while (expected_headers.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (!empty)
        begin
            $error("result item left over with none expected, status %0d", status);
            mismatches++;
        end

        if (mismatches == 0)
            $display("file_delivery_pdu_header_parser_top: match");
        else
            $display("file_delivery_pdu_header_parser_top: mismatch");
        $finish;
    end

    // watchdog
    initial
    begin : watchdog
        #1_000_000;
        $display("file_delivery_pdu_header_parser_top: mismatch");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/fdphp_pkg.sv
hdl/fdphp_front.sv
hdl/fdphp_queue.sv
hdl/fdphp_back.sv
hdl/file_delivery_pdu_header_parser_top.sv
verif/file_delivery_pdu_header_parser_top_tb.sv
